// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared property shapes for the checkers, clocked on clk with async rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// bss_pkg
// shared types and constants of the byte substring search block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bss_pkg;

    localparam int NEEDLE_MAX = 16;
    localparam int NLEN_W     = $clog2(NEEDLE_MAX + 1);
    localparam int HAY_CNT_W  = 25;
    localparam int OFFSET_W   = 24;
    localparam int OPCODE_W   = 2;
    localparam int BYTE_W     = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_NEEDLE = 2'd1,
        OP_HAY    = 2'd2,
        OP_END    = 2'd3
    } opcode_t;

endpackage

`default_nettype wire

// ===== rtl/byte_substring_search.sv =====
// ----------------------------------------------------------------------------
// byte_substring_search
// streaming first-occurrence search of a short needle in a byte haystack
// ----------------------------------------------------------------------------
// Takes one input word per cycle with no bubbles, apart from the stall below:
// words land in an input register and are processed from there by a parallel
// compare of the needle against the newest haystack bytes, and a result leaves
// through the output register once its end-of-haystack word has passed the
// input register. The sustained rate is one word per clock; input stalls
// only while an end-of-haystack word waits behind an
// unaccepted result. s_tuser carries the opcode (clear, needle byte, haystack
// byte, end), s_tdata the byte. m_tuser is the found flag and m_tdata the
// offset of the first match (zero when not found). An empty needle matches at
// offset 0, needle bytes past the needle capacity and haystack bytes past the
// haystack limit are dropped, and loading a needle byte restarts the search.
`timescale 1ns / 1ps
`default_nettype none

module byte_substring_search (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [bss_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  wire logic [bss_pkg::OPCODE_W-1:0] s_tuser,   // [1:0] opcode
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [bss_pkg::OFFSET_W-1:0]      m_tdata,   // [23:0] match_offset
    output logic                              m_tuser    // [0] found
);

    import bss_pkg::*;

    // input register
    logic                   in_valid_reg;
    opcode_t                in_op_reg;
    logic [BYTE_W-1:0]      in_byte_reg;

    // search state
    logic [BYTE_W-1:0]      needle_reg [NEEDLE_MAX];   // newest needle byte at 0
    logic [BYTE_W-1:0]      window_reg [NEEDLE_MAX];   // newest haystack byte at 0
    logic [NLEN_W-1:0]      needle_len_reg;
    logic [HAY_CNT_W-1:0]   hay_cnt_reg;
    logic                   match_seen_reg;
    logic [OFFSET_W-1:0]    first_match_reg;

    // result register
    logic                   out_valid_reg;
    logic                   out_found_reg;
    logic [OFFSET_W-1:0]    out_offset_reg;

    logic                   advance;
    logic                   hay_take;
    logic                   needle_take;
    logic [BYTE_W-1:0]      window_next [NEEDLE_MAX];
    logic [HAY_CNT_W-1:0]   hay_cnt_next;
    logic [HAY_CNT_W-1:0]   len_ext;
    logic                   window_hit;
    logic                   new_match;
    logic [HAY_CNT_W-1:0]   start_pos;

    // the end word is the only one that needs room in the result register
    assign advance = in_valid_reg &&
                     ((in_op_reg != OP_END) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign hay_take    = advance && (in_op_reg == OP_HAY) && !hay_cnt_reg[HAY_CNT_W-1];
    assign needle_take = advance && (in_op_reg == OP_NEEDLE) &&
                         (needle_len_reg < NLEN_W'(NEEDLE_MAX));

    always_comb
    begin
        window_next[0] = in_byte_reg;
        for (int i = 1; i < NEEDLE_MAX; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    // needle is kept reversed, so needle position j lines up with window slot j
    always_comb
    begin
        window_hit = 1'b1;
        for (int j = 0; j < NEEDLE_MAX; j++)
        begin
            if ((NLEN_W'(j) < needle_len_reg) && (needle_reg[j] != window_next[j]))
            begin
                window_hit = 1'b0;
            end
        end
    end

    assign hay_cnt_next = hay_cnt_reg + HAY_CNT_W'(1);
    assign len_ext      = HAY_CNT_W'(needle_len_reg);
    assign start_pos    = hay_cnt_next - len_ext;
    assign new_match    = hay_take && !match_seen_reg && (needle_len_reg != '0) &&
                          (hay_cnt_next >= len_ext) && window_hit;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            needle_len_reg <= '0;
            hay_cnt_reg    <= '0;
            match_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end

            if (advance && (in_op_reg == OP_END))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                case (in_op_reg)
                    OP_CLEAR:
                    begin
                        needle_len_reg <= '0;
                        hay_cnt_reg    <= '0;
                        match_seen_reg <= 1'b0;
                    end
                    OP_NEEDLE:
                    begin
                        if (needle_take)
                        begin
                            needle_len_reg <= needle_len_reg + NLEN_W'(1);
                        end
                        hay_cnt_reg    <= '0;
                        match_seen_reg <= 1'b0;
                    end
                    OP_HAY:
                    begin
                        if (hay_take)
                        begin
                            hay_cnt_reg <= hay_cnt_next;
                        end
                        if (new_match)
                        begin
                            match_seen_reg <= 1'b1;
                        end
                    end
                    OP_END:
                    begin
                        hay_cnt_reg    <= '0;
                        match_seen_reg <= 1'b0;
                    end
                    default:
                    begin
                        needle_len_reg <= needle_len_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= opcode_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end

        if (needle_take)
        begin
            needle_reg[0] <= in_byte_reg;
            for (int i = 1; i < NEEDLE_MAX; i++)
            begin
                needle_reg[i] <= needle_reg[i-1];
            end
        end

        if (hay_take)
        begin
            for (int i = 0; i < NEEDLE_MAX; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end

        if (new_match)
        begin
            first_match_reg <= start_pos[OFFSET_W-1:0];
        end

        if (advance && (in_op_reg == OP_END))
        begin
            out_found_reg  <= (needle_len_reg == '0) || match_seen_reg;
            out_offset_reg <= ((needle_len_reg != '0) && match_seen_reg) ?
                              first_match_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_offset_reg;
    assign m_tuser  = out_found_reg;

endmodule

`default_nettype wire

// ===== rtl/bss_checker.sv =====
// ----------------------------------------------------------------------------
// bss_checker
// port-level checks of the byte substring search block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bss_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_tvalid,
    input wire logic                         s_tready,
    input wire logic [bss_pkg::BYTE_W-1:0]   s_tdata,
    input wire logic [bss_pkg::OPCODE_W-1:0] s_tuser,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [bss_pkg::OFFSET_W-1:0] m_tdata,
    input wire logic                         m_tuser
);

    import bss_pkg::*;

    // a stalled result word holds
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // not found always reports offset zero
    `ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser, m_tdata == '0)

    // input only backs up behind a pending result
    `ASSERT_IMP(a_ready_free, !m_tvalid, s_tready)

    // an accepted end word with no pending result shows up after the input and result registers
    `ASSERT_IMP(a_end_result,
                $past(s_tvalid && s_tready && (s_tuser == OP_END), 2) &&
                !$past(m_tvalid, 1) && !$past(m_tvalid, 2),
                m_tvalid)

endmodule

bind byte_substring_search bss_checker u_bss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
